// ----- rtl/sctt_pkg.sv -----
package sctt_pkg;

    localparam int CODE_W    = 16;
    localparam int VAL_W     = 16;
    localparam int FRAC_W    = 28;
    localparam int MANT_W    = 30;
    localparam int TAB_W     = 29;
    localparam int LOG_IN_W  = 39;
    localparam int LOG_OUT_W = 34;
    localparam int P_W       = 6;
    localparam int Q_W       = 17;
    localparam int NUM_W     = 64;
    localparam int DEN_W     = 48;

    localparam logic [22:0] N_PER_CODE = 23'd6545968;
    localparam logic [36:0] D_BASE     = 37'd120000000000;
    localparam logic [20:0] D_PER_CODE = 21'd1831040;
    localparam logic [27:0] LN2_Q28    = 28'd186065279;
    localparam logic [14:0] T0_CENTI   = 15'd29815;
    localparam logic [DEN_W-1:0] BETA_BASE = 48'd356000 << FRAC_W;
    localparam logic [NUM_W-1:0] KELVIN_NUM = 64'd10614140000 << FRAC_W;
    localparam logic [Q_W-1:0] ZERO_C_CENTI = 17'd27315;
    localparam logic [Q_W-1:0] Q_MAX        = 17'd60082;
    localparam logic [TAB_W-1:0] LOG2_ONE   = 29'd1 << FRAC_W;

    localparam logic [31:0] HUM_MUL = 32'd12500;
    localparam logic [31:0] TMP_MUL = 32'd17572;
    localparam logic [31:0] ROUND16 = 32'd32768;
    localparam logic signed [VAL_W-1:0] HUM_OFF = 16'sd600;
    localparam logic signed [VAL_W-1:0] TMP_OFF = 16'sd4685;
    localparam logic signed [VAL_W-1:0] VAL_MAX = 16'sd32767;

    localparam logic STATUS_OK  = 1'b0;
    localparam logic STATUS_ERR = 1'b1;

    localparam int LOG_STAGES = 6;
    localparam int DIV_BPS    = 2;
    localparam int DIV_STAGES = (Q_W + DIV_BPS - 1) / DIV_BPS;

    localparam int S_FRONT  = 0;
    localparam int S_LOG0   = 1;
    localparam int S_DIFF   = S_LOG0 + LOG_STAGES;
    localparam int S_LNMUL  = S_DIFF + 1;
    localparam int S_LNRND  = S_LNMUL + 1;
    localparam int S_DENMUL = S_LNRND + 1;
    localparam int S_DEN    = S_DENMUL + 1;
    localparam int S_NUM    = S_DEN + 1;
    localparam int S_OVF    = S_NUM + 1;
    localparam int S_DIV0   = S_OVF + 1;
    localparam int S_OUT    = S_DIV0 + DIV_STAGES;
    localparam int N_STAGES = S_OUT + 1;

    typedef enum logic [1:0] {
        FUNC_THERM   = 2'd0,
        FUNC_HUM     = 2'd1,
        FUNC_TEMP    = 2'd2,
        FUNC_UNKNOWN = 2'd3
    } func_t;

    typedef struct packed {
        func_t                    func;
        logic                     read_ok;
        logic                     code_zero;
        logic                     sat;
        logic signed [VAL_W-1:0]  lin;
    } side_t;

    // log2 of a Q30 mantissa in [1,2), Q28 result, by repeated squaring
    function automatic logic [TAB_W-1:0] frac_log2(input logic [MANT_W:0] m_in);
        logic [63:0]      m;
        logic [TAB_W-1:0] r;
        m = 64'(m_in);
        r = '0;
        for (int k = 0; k < FRAC_W; k++)
        begin
            m = (m * m) >> MANT_W;
            r = {r[TAB_W-2:0], 1'b0};
            if (m >= (64'd2 << MANT_W))
            begin
                r[0] = 1'b1;
                m    = m >> 1;
            end
        end
        return r;
    endfunction

endpackage

// ----- rtl/sctt_log2.sv -----
module sctt_log2 #(
    parameter int LOG_TABLE_ENTRIES = 256
) (
    input  logic                                   clk,
    input  logic [sctt_pkg::LOG_STAGES-1:0]        en,
    input  logic [sctt_pkg::LOG_IN_W-1:0]          v,
    output logic [sctt_pkg::LOG_OUT_W-1:0]         log2
);

    localparam int IDX_W = $clog2(LOG_TABLE_ENTRIES + 1);
    localparam int POS_W = sctt_pkg::MANT_W + IDX_W;
    localparam int TW    = sctt_pkg::TAB_W;
    localparam int IW    = sctt_pkg::LOG_IN_W;
    localparam int MW    = sctt_pkg::MANT_W;

    logic [TW-1:0] tab [LOG_TABLE_ENTRIES+1];

    for (genvar i = 0; i <= LOG_TABLE_ENTRIES; i++)
    begin : g_tab
        localparam longint unsigned STEP = (64'(i) << MW) / 64'(LOG_TABLE_ENTRIES);
        localparam logic [TW-1:0] ENTRY = (i == LOG_TABLE_ENTRIES) ? sctt_pkg::LOG2_ONE :
            sctt_pkg::frac_log2((MW+1)'((64'd1 << MW) + STEP));
        assign tab[i] = ENTRY;
    end

    // normalize: coarse shifts, then fine shifts
    logic [IW-1:0] x1_next, x1_reg, x2_next, x2_reg;
    logic [2:0]    lz1_next, lz1_reg;
    logic [2:0]    lz2_lo;
    logic [sctt_pkg::P_W-1:0] lz2_reg;

    always_comb
    begin
        x1_next  = v;
        lz1_next = '0;
        if (x1_next[IW-1 -: 32] == '0)
        begin
            x1_next     = x1_next << 32;
            lz1_next[2] = 1'b1;
        end
        if (x1_next[IW-1 -: 16] == '0)
        begin
            x1_next     = x1_next << 16;
            lz1_next[1] = 1'b1;
        end
        if (x1_next[IW-1 -: 8] == '0)
        begin
            x1_next     = x1_next << 8;
            lz1_next[0] = 1'b1;
        end
    end

    always_comb
    begin
        x2_next = x1_reg;
        lz2_lo  = '0;
        if (x2_next[IW-1 -: 4] == '0)
        begin
            x2_next   = x2_next << 4;
            lz2_lo[2] = 1'b1;
        end
        if (x2_next[IW-1 -: 2] == '0)
        begin
            x2_next   = x2_next << 2;
            lz2_lo[1] = 1'b1;
        end
        if (!x2_next[IW-1])
        begin
            x2_next   = x2_next << 1;
            lz2_lo[0] = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            x1_reg  <= x1_next;
            lz1_reg <= lz1_next;
        end
        if (en[1])
        begin
            x2_reg  <= x2_next;
            lz2_reg <= {lz1_reg, lz2_lo};
        end
    end

    // table position from the fraction of the mantissa
    logic [POS_W-1:0] pos;
    logic [IDX_W-1:0] idx_next, idx_reg;
    logic [MW-1:0]    rem3_reg, rem4_reg;
    logic [sctt_pkg::P_W-1:0] p3_reg, p4_reg, p5_reg;

    always_comb
    begin
        pos      = POS_W'(x2_reg[IW-2 -: MW]) * POS_W'(LOG_TABLE_ENTRIES);
        idx_next = pos[POS_W-1:MW];
        if (idx_next >= IDX_W'(LOG_TABLE_ENTRIES))
        begin
            idx_next = IDX_W'(LOG_TABLE_ENTRIES - 1);
        end
    end

    logic [TW-1:0] a4_reg, b4_reg, a5_reg, pr5_reg, lo_b, dif;
    logic [TW+MW-1:0] prod;

    always_comb
    begin
        lo_b = (b4_reg < a4_reg) ? a4_reg : b4_reg;
        dif  = lo_b - a4_reg;
        prod = (TW+MW)'(dif) * (TW+MW)'(rem4_reg);
    end

    logic [sctt_pkg::LOG_OUT_W-1:0] out_reg;

    always_ff @(posedge clk)
    begin
        if (en[2])
        begin
            idx_reg  <= idx_next;
            rem3_reg <= pos[MW-1:0];
            p3_reg   <= sctt_pkg::P_W'(IW - 1) - lz2_reg;
        end
        if (en[3])
        begin
            a4_reg   <= tab[idx_reg];
            b4_reg   <= tab[idx_reg + IDX_W'(1)];
            rem4_reg <= rem3_reg;
            p4_reg   <= p3_reg;
        end
        if (en[4])
        begin
            a5_reg  <= a4_reg;
            pr5_reg <= prod[TW+MW-1:MW];
            p5_reg  <= p4_reg;
        end
        if (en[5])
        begin
            out_reg <= {p5_reg, sctt_pkg::FRAC_W'(0)}
                + sctt_pkg::LOG_OUT_W'(a5_reg) + sctt_pkg::LOG_OUT_W'(pr5_reg);
        end
    end

    assign log2 = out_reg;

endmodule

// ----- rtl/sctt_div.sv -----
module sctt_div (
    input  logic                                 clk,
    input  logic [sctt_pkg::DIV_STAGES-1:0]      en,
    input  logic [sctt_pkg::NUM_W-1:0]           num,
    input  logic [sctt_pkg::DEN_W-1:0]           den,
    output logic [sctt_pkg::Q_W-1:0]             quot
);

    localparam int NS  = sctt_pkg::DIV_STAGES;
    localparam int BPS = sctt_pkg::DIV_BPS;
    localparam int QW  = sctt_pkg::Q_W;
    localparam int NW  = sctt_pkg::NUM_W;
    localparam int DW  = sctt_pkg::DEN_W;

    logic [NW-1:0] rem_reg [NS];
    logic [DW-1:0] dv_reg  [NS];
    logic [QW-1:0] q_reg   [NS];

    for (genvar j = 0; j < NS; j++)
    begin : g_stage
        localparam int FIRST = j * BPS;
        localparam int NSTEP = (QW - FIRST < BPS) ? (QW - FIRST) : BPS;

        logic [NW-1:0] r_in, r_c;
        logic [DW-1:0] d_in;
        logic [QW-1:0] q_in, q_c;

        if (j == 0)
        begin : g_head
            assign r_in = num;
            assign d_in = den;
            assign q_in = '0;
        end
        else
        begin : g_body
            assign r_in = rem_reg[j-1];
            assign d_in = dv_reg[j-1];
            assign q_in = q_reg[j-1];
        end

        // restoring division, one quotient bit per step
        always_comb
        begin
            logic [NW-1:0] sh;
            r_c = r_in;
            q_c = q_in;
            for (int b = 0; b < NSTEP; b++)
            begin
                sh = NW'(d_in) << (QW - 1 - FIRST - b);
                if (r_c >= sh)
                begin
                    r_c = r_c - sh;
                    q_c = {q_c[QW-2:0], 1'b1};
                end
                else
                begin
                    q_c = {q_c[QW-2:0], 1'b0};
                end
            end
        end

        always_ff @(posedge clk)
        begin
            if (en[j])
            begin
                rem_reg[j] <= r_c;
                dv_reg[j]  <= d_in;
                q_reg[j]   <= q_c;
            end
        end
    end

    assign quot = q_reg[NS-1];

endmodule

// ----- rtl/sensor_code_to_temperature.sv -----
// Channel  Dir  Handshake              Payload
// in       in   in_valid / in_stall    func[1:0], raw_code[15:0], read_ok
// out      out  out_valid / out_stall  value_centi[15:0] signed, status
//
// One request per cycle while in_stall is low.
// The pipeline includes the 6-stage log2 unit and the 9-stage divider (2 bits/stage).
// Reset clears only the stage valid bits.
// A stall on out holds the last stage; earlier stages keep moving into empty slots,
// so in_stall rises only when every stage holds a request.
module sensor_code_to_temperature #(
    parameter int LOG_TABLE_ENTRIES = 256
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_stall,
    input  logic [1:0]                func,
    input  logic [15:0]               raw_code,
    input  logic                      read_ok,
    output logic                      out_valid,
    input  logic                      out_stall,
    output logic signed [15:0]        value_centi,
    output logic                      status
);

    localparam int NS = sctt_pkg::N_STAGES;

    logic [NS-1:0] valid_reg, valid_next, adv;

    always_comb
    begin
        adv[NS-1] = !valid_reg[NS-1] || !out_stall;
        for (int s = NS - 2; s >= 0; s--)
        begin
            adv[s] = !valid_reg[s] || adv[s+1];
        end
        valid_next[0] = in_valid;
        for (int s = 1; s < NS; s++)
        begin
            valid_next[s] = valid_reg[s-1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            for (int s = 0; s < NS; s++)
            begin
                if (adv[s])
                begin
                    valid_reg[s] <= valid_next[s];
                end
            end
        end
    end

    assign in_stall  = !adv[0];
    assign out_valid = valid_reg[sctt_pkg::S_OUT];

    // side info travels with each request
    sctt_pkg::side_t side_reg  [sctt_pkg::S_OUT];
    sctt_pkg::side_t side_next [sctt_pkg::S_OUT];
    logic den_bad, ovf;

    // front stage
    logic [31:0] hum_t, tmp_t;
    sctt_pkg::side_t side0;
    logic [sctt_pkg::LOG_IN_W-1:0] n_reg;
    logic [36:0] d_reg;

    always_comb
    begin
        hum_t = 32'(raw_code) * sctt_pkg::HUM_MUL + sctt_pkg::ROUND16;
        tmp_t = 32'(raw_code) * sctt_pkg::TMP_MUL + sctt_pkg::ROUND16;
        side0.func      = sctt_pkg::func_t'(func);
        side0.read_ok   = read_ok;
        side0.code_zero = (raw_code == '0);
        side0.sat       = 1'b0;
        if (sctt_pkg::func_t'(func) == sctt_pkg::FUNC_HUM)
        begin
            side0.lin = $signed(hum_t[31:16]) - sctt_pkg::HUM_OFF;
        end
        else
        begin
            side0.lin = $signed(tmp_t[31:16]) - sctt_pkg::TMP_OFF;
        end
    end

    always_comb
    begin
        side_next[0] = side0;
        for (int s = 1; s < sctt_pkg::S_OUT; s++)
        begin
            side_next[s] = side_reg[s-1];
        end
        side_next[sctt_pkg::S_DEN].sat = side_reg[sctt_pkg::S_DEN-1].sat | den_bad;
        side_next[sctt_pkg::S_OVF].sat = side_reg[sctt_pkg::S_OVF-1].sat | ovf;
    end

    always_ff @(posedge clk)
    begin
        for (int s = 0; s < sctt_pkg::S_OUT; s++)
        begin
            if (adv[s])
            begin
                side_reg[s] <= side_next[s];
            end
        end
        if (adv[sctt_pkg::S_FRONT])
        begin
            n_reg <= sctt_pkg::LOG_IN_W'(sctt_pkg::N_PER_CODE)
                * sctt_pkg::LOG_IN_W'(raw_code);
            d_reg <= sctt_pkg::D_BASE - 37'(sctt_pkg::D_PER_CODE) * 37'(raw_code);
        end
    end

    // log2 of numerator and denominator of Rt/2000
    logic [sctt_pkg::LOG_OUT_W-1:0] log_n, log_d;

    sctt_log2 #(.LOG_TABLE_ENTRIES(LOG_TABLE_ENTRIES)) u_log_n (
        .clk  (clk),
        .en   (adv[sctt_pkg::S_LOG0 +: sctt_pkg::LOG_STAGES]),
        .v    (n_reg),
        .log2 (log_n)
    );

    sctt_log2 #(.LOG_TABLE_ENTRIES(LOG_TABLE_ENTRIES)) u_log_d (
        .clk  (clk),
        .en   (adv[sctt_pkg::S_LOG0 +: sctt_pkg::LOG_STAGES]),
        .v    (sctt_pkg::LOG_IN_W'(d_reg)),
        .log2 (log_d)
    );

    // ln = (log2 n - log2 d) * ln2, rounded half away from zero
    logic signed [34:0] diff;
    logic [34:0]        diff_abs;
    logic               neg7_reg, neg8_reg, neg9_reg, neg10_reg;
    logic [32:0]        mag_reg;
    logic [44:0]        ph_reg;
    logic [43:0]        pl_reg;
    logic [60:0]        ln_sum;
    logic [31:0]        r_reg;
    logic [46:0]        pm_reg;
    logic signed [48:0] den49;
    logic [sctt_pkg::DEN_W-1:0] den_reg, den12_reg, den13_reg;
    logic [sctt_pkg::NUM_W-1:0] nn12_reg, nn13_reg;

    always_comb
    begin
        diff     = $signed({1'b0, log_n}) - $signed({1'b0, log_d});
        diff_abs = diff[34] ? 35'(-diff) : 35'(diff);
        ln_sum   = {ph_reg, 16'b0} + 61'(pl_reg) + (61'd1 << (sctt_pkg::FRAC_W - 1));
        if (neg10_reg)
        begin
            den49 = $signed({1'b0, sctt_pkg::BETA_BASE}) - $signed({2'b0, pm_reg});
        end
        else
        begin
            den49 = $signed({1'b0, sctt_pkg::BETA_BASE}) + $signed({2'b0, pm_reg});
        end
        den_bad = den49[48] || (den49 == '0);
        ovf     = {1'b0, nn12_reg} >= {den12_reg, 17'b0};
    end

    always_ff @(posedge clk)
    begin
        if (adv[sctt_pkg::S_DIFF])
        begin
            neg7_reg <= diff[34];
            mag_reg  <= diff_abs[32:0];
        end
        if (adv[sctt_pkg::S_LNMUL])
        begin
            neg8_reg <= neg7_reg;
            ph_reg   <= 45'(mag_reg[32:16]) * 45'(sctt_pkg::LN2_Q28);
            pl_reg   <= 44'(mag_reg[15:0]) * 44'(sctt_pkg::LN2_Q28);
        end
        if (adv[sctt_pkg::S_LNRND])
        begin
            neg9_reg <= neg8_reg;
            r_reg    <= ln_sum[59:28];
        end
        if (adv[sctt_pkg::S_DENMUL])
        begin
            neg10_reg <= neg9_reg;
            pm_reg    <= 47'(r_reg) * 47'(sctt_pkg::T0_CENTI);
        end
        if (adv[sctt_pkg::S_DEN])
        begin
            den_reg <= den49[47:0];
        end
        if (adv[sctt_pkg::S_NUM])
        begin
            nn12_reg  <= sctt_pkg::KELVIN_NUM + sctt_pkg::NUM_W'(den_reg[47:1]);
            den12_reg <= den_reg;
        end
        if (adv[sctt_pkg::S_OVF])
        begin
            nn13_reg  <= nn12_reg;
            den13_reg <= den12_reg;
        end
    end

    // centi-kelvin quotient
    logic [sctt_pkg::Q_W-1:0] quot;

    sctt_div u_div (
        .clk  (clk),
        .en   (adv[sctt_pkg::S_DIV0 +: sctt_pkg::DIV_STAGES]),
        .num  (nn13_reg),
        .den  (den13_reg),
        .quot (quot)
    );

    // result select and saturation
    sctt_pkg::side_t sd;
    logic [sctt_pkg::Q_W-1:0] kel;
    logic signed [15:0] val_next, val_reg;
    logic st_next, st_reg;

    always_comb
    begin
        sd       = side_reg[sctt_pkg::S_OUT-1];
        kel      = quot - sctt_pkg::ZERO_C_CENTI;
        val_next = '0;
        st_next  = sctt_pkg::STATUS_OK;
        case (sd.func)
            sctt_pkg::FUNC_THERM:
            begin
                if (!sd.read_ok)
                begin
                    st_next = sctt_pkg::STATUS_ERR;
                end
                else if (sd.sat || sd.code_zero || (quot > sctt_pkg::Q_MAX))
                begin
                    val_next = sctt_pkg::VAL_MAX;
                end
                else
                begin
                    val_next = $signed(kel[15:0]);
                end
            end
            sctt_pkg::FUNC_HUM, sctt_pkg::FUNC_TEMP:
            begin
                if (!sd.read_ok)
                begin
                    st_next = sctt_pkg::STATUS_ERR;
                end
                else
                begin
                    val_next = sd.lin;
                end
            end
            default:
            begin
                val_next = '0;
                st_next  = sctt_pkg::STATUS_OK;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (adv[sctt_pkg::S_OUT])
        begin
            val_reg <= val_next;
            st_reg  <= st_next;
        end
    end

    assign value_centi = val_reg;
    assign status      = st_reg;

    logic in_acc, out_acc;
    assign in_acc  = in_valid && !in_stall;
    assign out_acc = out_valid && !out_stall;

    a_no_false_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> !in_stall)
        else $error("input stalled while pipeline has room");

    a_count: assert property (@(posedge clk) disable iff (!rst_n)
        1'b1 |=> $countones(valid_reg) == $past($countones(valid_reg))
            + int'($past(in_acc)) - int'($past(out_acc)))
        else $error("request lost or duplicated in pipeline");

    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status |-> value_centi == '0)
        else $error("read error result carries a nonzero value");

endmodule
